// ===== design/remedian_base5_median_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the base-5 remedian estimator
// Checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REMEDIAN_BASE5_MEDIAN_MACROS_SVH
`define REMEDIAN_BASE5_MEDIAN_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define RBM_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error(msg);
// condition must never be true outside reset
`define RBM_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	!(cond)) else $error(msg);
`else
`define RBM_ASSERT(lbl, prop, msg)
`define RBM_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbm_pkg
// Constants, types and the sort schedule of the base-5 remedian estimator.
// ----------------------------------------------------------------------------
package rbm_pkg;

	localparam int LEVELS      = 8;
	localparam int SAMPLE_BITS = 32;
	localparam int SLOTS       = 4;
	localparam int GROUP       = 5;
	localparam int SORT_STEPS  = 10;

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ADDR_W = LVL_W + 2;
	localparam int DEPTH  = LEVELS * SLOTS;

	// largest signed value, used to pad short groups before sorting
	localparam logic signed [SAMPLE_BITS-1:0] PAD_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLACE,
		ST_LOAD,
		ST_SORT,
		ST_CARRY,
		ST_FIND,
		ST_EMIT
	} state_t;

	// Bubble-sort schedule over five entries: lower index of the pair
	// that is compared and exchanged at each step.
	function automatic logic [2:0] pair_lo(input logic [3:0] step);
		logic [2:0] r;
		case (step)
			4'd0, 4'd4, 4'd7, 4'd9: r = 3'd0;
			4'd1, 4'd5, 4'd8:       r = 3'd1;
			4'd2, 4'd6:             r = 3'd2;
			4'd3:                   r = 3'd3;
			default:                r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/remedian_base5_median.sv =====
// ----------------------------------------------------------------------------
// remedian_base5_median
// Streaming base-5 remedian: samples fill level 0, every full group of five
// carries its median one level up; the word marked last returns the median
// of the highest nonempty level.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                       Word contents
// s_*       in   s_tvalid s_tready s_tdata     tdata[31:0] sample, tlast final_item
//                s_tlast
// m_*       out  m_tvalid m_tready m_tdata     tdata[31:0] median_value,
//                m_tuser                       tuser overflowed
//
// A sample that lands in level 0 is accepted in idle, then placed.
// Each carry reads a level row from the level RAM, runs 10 steps of
// the single compare-exchange unit, then carries and places the median.
// A last word adds a level search, a load and sort, then the emit.
// s_tready is high only while the sequencer idles; the result register
// lets the next word in while a median waits on m_tready, but a second
// last word holds in emit until that median is taken.
// Reset clears fill counts, overflow flag and handshakes; RAM is not cleared.
// ----------------------------------------------------------------------------
module remedian_base5_median (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rbm_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [31:0] sample
	input  logic                              s_tlast,   // final_item
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbm_pkg::SAMPLE_BITS-1:0]   m_tdata,   // [31:0] median_value
	output logic                              m_tuser    // overflowed
);

	`include "remedian_base5_median_macros.svh"

	rbm_pkg::state_t state_q, state_d;

	// level RAM and its registered read port
	rbm_pkg::sample_t            mem [rbm_pkg::DEPTH];
	rbm_pkg::sample_t            rd_data_q;
	logic [rbm_pkg::ADDR_W-1:0]  rd_addr;
	logic [rbm_pkg::ADDR_W-1:0]  wr_addr;
	logic                        wr_en;

	logic [2:0]                  fill_q [rbm_pkg::LEVELS];
	logic                        ovf_q;
	rbm_pkg::sample_t            v_q;
	logic                        last_q;
	logic                        fin_q;
	logic [rbm_pkg::LVL_W-1:0]   lv_q;
	logic [2:0]                  n_q;
	logic [2:0]                  cnt_q;
	logic [3:0]                  step_q;
	rbm_pkg::sample_t            buf_q [rbm_pkg::GROUP];

	logic                        m_tvalid_q;
	rbm_pkg::sample_t            m_tdata_q;
	logic                        m_tuser_q;

	logic [2:0]                  fill_cur;
	logic                        lvl_full;
	logic                        top_lvl;
	logic                        out_free;
	logic [2:0]                  pi;
	rbm_pkg::sample_t            cmp_lo, cmp_hi;
	logic                        do_swap;
	logic [rbm_pkg::LVL_W-1:0]   top_idx;
	logic                        top_found;
	rbm_pkg::sample_t            med;
	logic [2:0]                  slot_idx;
	logic                        pad_slot;

	assign s_tready = (state_q == rbm_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign fill_cur = fill_q[lv_q];
	assign lvl_full = (fill_cur == 3'(rbm_pkg::SLOTS));
	assign top_lvl  = (lv_q == rbm_pkg::LVL_W'(rbm_pkg::LEVELS - 1));
	assign out_free = !m_tvalid_q || m_tready;

	// shared compare-exchange unit
	assign pi      = rbm_pkg::pair_lo(step_q);
	assign cmp_lo  = buf_q[pi];
	assign cmp_hi  = buf_q[pi + 3'd1];
	assign do_swap = (cmp_hi < cmp_lo);

	// slot captured during a row load; slots past the count are padded
	assign slot_idx = cnt_q - 3'd1;
	assign pad_slot = fin_q && (slot_idx >= n_q);

	// upper median of the final group, zero when every level is empty
	assign med = fin_q ? buf_q[{1'b0, n_q[2:1]}] : '0;

	assign rd_addr = {lv_q, cnt_q[1:0]};
	assign wr_addr = {lv_q, fill_cur[1:0]};
	assign wr_en   = (state_q == rbm_pkg::ST_PLACE) && !lvl_full;

	// highest nonempty level
	always_comb begin
		top_idx   = '0;
		top_found = 1'b0;
		for (int i = 0; i < rbm_pkg::LEVELS; i++) begin
			if (fill_q[i] != 3'd0) begin
				top_idx   = rbm_pkg::LVL_W'(i);
				top_found = 1'b1;
			end
		end
	end

	// level RAM
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= v_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbm_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = rbm_pkg::ST_PLACE;
			end
			rbm_pkg::ST_PLACE: begin
				if (lvl_full)    state_d = rbm_pkg::ST_LOAD;
				else if (last_q) state_d = rbm_pkg::ST_FIND;
				else             state_d = rbm_pkg::ST_IDLE;
			end
			rbm_pkg::ST_LOAD: begin
				if (cnt_q == 3'(rbm_pkg::SLOTS)) state_d = rbm_pkg::ST_SORT;
			end
			rbm_pkg::ST_SORT: begin
				if (step_q == 4'(rbm_pkg::SORT_STEPS - 1)) begin
					state_d = fin_q ? rbm_pkg::ST_EMIT : rbm_pkg::ST_CARRY;
				end
			end
			rbm_pkg::ST_CARRY: begin
				if (!top_lvl)    state_d = rbm_pkg::ST_PLACE;
				else if (last_q) state_d = rbm_pkg::ST_FIND;
				else             state_d = rbm_pkg::ST_IDLE;
			end
			rbm_pkg::ST_FIND: begin
				state_d = top_found ? rbm_pkg::ST_LOAD : rbm_pkg::ST_EMIT;
			end
			rbm_pkg::ST_EMIT: begin
				if (out_free) state_d = rbm_pkg::ST_IDLE;
			end
			default: state_d = rbm_pkg::ST_IDLE;
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbm_pkg::LEVELS; i++) fill_q[i] <= 3'd0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			fin_q      <= 1'b0;
			lv_q       <= '0;
			n_q        <= 3'd0;
			cnt_q      <= 3'd0;
			step_q     <= 4'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result valid: set on emit, dropped once taken
			if (state_q == rbm_pkg::ST_EMIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                            m_tvalid_q <= 1'b0;
			case (state_q)
				rbm_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						last_q <= s_tlast;
						fin_q  <= 1'b0;
						lv_q   <= '0;
					end
				end
				rbm_pkg::ST_PLACE: begin
					cnt_q <= 3'd0;
					if (!lvl_full) fill_q[lv_q] <= fill_cur + 3'd1;
				end
				rbm_pkg::ST_LOAD: begin
					cnt_q  <= cnt_q + 3'd1;
					step_q <= 4'd0;
				end
				rbm_pkg::ST_SORT: begin
					step_q <= step_q + 4'd1;
				end
				rbm_pkg::ST_CARRY: begin
					fill_q[lv_q] <= 3'd0;
					if (top_lvl) ovf_q <= 1'b1;
					else         lv_q  <= lv_q + 1'b1;
				end
				rbm_pkg::ST_FIND: begin
					lv_q  <= top_idx;
					n_q   <= fill_q[top_idx];
					fin_q <= top_found;
					cnt_q <= 3'd0;
				end
				rbm_pkg::ST_EMIT: begin
					if (out_free) begin
						ovf_q <= 1'b0;
						for (int i = 0; i < rbm_pkg::LEVELS; i++) fill_q[i] <= 3'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: carried value, sort buffer, result word
	always_ff @(posedge clk) begin
		case (state_q)
			rbm_pkg::ST_IDLE: begin
				if (s_tvalid) v_q <= s_tdata;
			end
			rbm_pkg::ST_LOAD: begin
				if (cnt_q != 3'd0) buf_q[slot_idx] <= pad_slot ? rbm_pkg::PAD_MAX : rd_data_q;
				if (cnt_q == 3'(rbm_pkg::SLOTS)) buf_q[rbm_pkg::SLOTS] <= fin_q ? rbm_pkg::PAD_MAX : v_q;
			end
			rbm_pkg::ST_SORT: begin
				if (do_swap) begin
					buf_q[pi]        <= cmp_hi;
					buf_q[pi + 3'd1] <= cmp_lo;
				end
			end
			rbm_pkg::ST_CARRY: begin
				v_q <= buf_q[rbm_pkg::GROUP / 2];
			end
			rbm_pkg::ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= med;
					m_tuser_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	`RBM_NEVER(a_fill0_range, fill_q[0] > 3'(rbm_pkg::SLOTS), "level 0 fill count above four")
	`RBM_ASSERT(a_carry_sorted, (state_q == rbm_pkg::ST_CARRY) |-> (buf_q[1] <= buf_q[2] && buf_q[2] <= buf_q[3]), "group not sorted at carry")
	`RBM_ASSERT(a_emit_clears, (state_q == rbm_pkg::ST_EMIT && out_free) |=> (!ovf_q && fill_q[0] == 3'd0 && m_tvalid), "state not cleared after result")

endmodule

// ===== sim/remedian_base5_median_tb.sv =====
// ----------------------------------------------------------------------------
// remedian_base5_median_tb
// Self-checking bench for the streaming base-5 remedian. Samples go in as
// words with tlast closing each data set; a scoreboard tracks the level
// contents, predicts the median and overflow flag of every set, and checks
// each output word in order. The run covers hand-picked sets, random sets
// of mixed lengths with random gaps and stalls on both sides, and a long
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------

// one output word: median and overflow flag
typedef struct packed {
	rbm_pkg::sample_t median_value;
	logic             overflowed;
} median_word_t;

// Level contents mirrored on every accepted sample; expected medians queued
class remedian_scoreboard;
	rbm_pkg::sample_t level_vals[rbm_pkg::LEVELS*rbm_pkg::SLOTS];
	int unsigned      level_cnt[rbm_pkg::LEVELS];
	bit               carry_lost;
	rbm_pkg::sample_t work[rbm_pkg::GROUP];
	median_word_t     pending_q[$];
	int unsigned      fail_count;

	function new();
		foreach (level_cnt[i]) level_cnt[i] = 0;
		carry_lost = 1'b0;
		fail_count = 0;
	endfunction

	// insertion sort of work[0..n-1], returns the entry at n/2
	function rbm_pkg::sample_t pick_middle(int n);
		rbm_pkg::sample_t x;
		int j;
		for (int i = 1; i < n; i++) begin
			x = work[i];
			j = i - 1;
			while (j >= 0 && x < work[j]) begin
				work[j+1] = work[j];
				j--;
			end
			work[j+1] = x;
		end
		return work[n/2];
	endfunction

	// accepted input word: ripple the sample up, queue a median on tlast
	function void note_sample(rbm_pkg::sample_t value, bit last);
		rbm_pkg::sample_t carry;
		bit               placed;
		int               top;
		int               n;
		median_word_t     w;
		carry  = value;
		placed = 1'b0;
		for (int lv = 0; lv < rbm_pkg::LEVELS && !placed; lv++) begin
			if (level_cnt[lv] < rbm_pkg::SLOTS) begin
				level_vals[lv*rbm_pkg::SLOTS + level_cnt[lv]] = carry;
				level_cnt[lv]++;
				placed = 1'b1;
			end else begin
				for (int k = 0; k < rbm_pkg::SLOTS; k++)
					work[k] = level_vals[lv*rbm_pkg::SLOTS + k];
				work[rbm_pkg::SLOTS] = carry;
				carry                = pick_middle(rbm_pkg::GROUP);
				level_cnt[lv]        = 0;
			end
		end
		if (!placed) carry_lost = 1'b1;
		if (!last) return;

		// highest nonempty level decides; lower levels are ignored
		top = -1;
		for (int lv = rbm_pkg::LEVELS - 1; lv >= 0 && top < 0; lv--)
			if (level_cnt[lv] > 0) top = lv;
		w.median_value = '0;
		if (top >= 0) begin
			n = level_cnt[top];
			for (int k = 0; k < n; k++) work[k] = level_vals[top*rbm_pkg::SLOTS + k];
			w.median_value = pick_middle(n);
		end
		w.overflowed = carry_lost;
		pending_q.push_back(w);
		foreach (level_cnt[i]) level_cnt[i] = 0;
		carry_lost = 1'b0;
	endfunction

	// accepted output word against the oldest expectation
	function void check_result(median_word_t got, realtime stamp);
		median_word_t want;
		if (pending_q.size() == 0) begin
			$display("%0.1f ns: unexpected word, median %0d overflow %0b",
				stamp, got.median_value, got.overflowed);
			fail_count++;
			return;
		end
		want = pending_q.pop_front();
		if (got.median_value !== want.median_value) begin
			$display("%0.1f ns: median_value expected %0d actual %0d",
				stamp, want.median_value, got.median_value);
			fail_count++;
		end
		if (got.overflowed !== want.overflowed) begin
			$display("%0.1f ns: overflowed expected %0b actual %0b",
				stamp, want.overflowed, got.overflowed);
			fail_count++;
		end
	endfunction

	function int pending();
		return pending_q.size();
	endfunction
endclass

module remedian_base5_median_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int               MAX_GAP        = 18;
	localparam int               HOLD_CYCLES    = 400;
	localparam int               WATCHDOG_LIMIT = 5000;
	localparam int               DRAIN_CYCLES   = 300;
	localparam int               RANDOM_ITEMS   = 2000;
	localparam rbm_pkg::sample_t SMIN = {1'b1, {(rbm_pkg::SAMPLE_BITS-1){1'b0}}};
	localparam rbm_pkg::sample_t SMAX = {1'b0, {(rbm_pkg::SAMPLE_BITS-1){1'b1}}};

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [rbm_pkg::SAMPLE_BITS-1:0] s_tdata  = '0;   // [31:0] sample
	logic                            s_tlast  = 1'b0; // final_item
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rbm_pkg::SAMPLE_BITS-1:0] m_tdata;         // [31:0] median_value
	logic                            m_tuser;         // overflowed

	remedian_scoreboard board = new();
	int unsigned send_gap_max = 0;
	int unsigned recv_gap_max = 0;
	int unsigned hold_request = 0;
	int unsigned quiet_cycles = 0;

	remedian_base5_median DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// no word moving on either side for too long ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// mostly full-range values, some clustered for ties, some extremes
	function automatic rbm_pkg::sample_t rand_sample();
		rbm_pkg::sample_t v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = SMIN;
					1: v = SMAX;
					2: v = '0;
					3: v = '1;
					default: v = 1;
				endcase
			end
			1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic int unsigned gap_limit();
		int unsigned g;
		case ($urandom_range(0, 3))
			0: g = 0;
			1: g = 3;
			default: g = MAX_GAP;
		endcase
		return g;
	endfunction

	// offer one input word after a random gap, wait for acceptance
	task automatic send_sample(rbm_pkg::sample_t value, bit last);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		board.note_sample(value, last);
		@(negedge clk);
	endtask

	task automatic send_set(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_sample(rand_sample(), i == len - 1);
	endtask

	// output side: random stalls, plus the long hold-off when requested
	initial begin : result_sink
		int unsigned  stall;
		median_word_t got;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, recv_gap_max);
			if (hold_request != 0) begin
				stall        = hold_request;
				hold_request = 0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.median_value = m_tdata;
			got.overflowed   = m_tuser;
			board.check_result(got, $realtime);
			@(negedge clk);
		end
	end

	// stimulus sequence
	initial begin : stimulus
		int unsigned items;
		int unsigned len;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sets: single extremes, even and odd counts, ties,
		// one carry to level 1, lower level ignored at the end
		send_gap_max = MAX_GAP;
		recv_gap_max = MAX_GAP;
		send_sample(SMIN, 1'b1);
		send_sample(SMAX, 1'b1);
		send_sample(SMAX, 1'b0); send_sample(SMIN, 1'b1);
		send_sample(-1, 1'b0); send_sample(1, 1'b0); send_sample(0, 1'b1);
		send_sample(7, 1'b0); send_sample(7, 1'b0); send_sample(7, 1'b0);
		send_sample(7, 1'b1);
		send_sample(SMAX, 1'b0); send_sample(SMIN, 1'b0); send_sample(-5, 1'b0);
		send_sample(3, 1'b0); send_sample(0, 1'b1);
		send_sample(1, 1'b0); send_sample(2, 1'b0); send_sample(3, 1'b0);
		send_sample(4, 1'b0); send_sample(5, 1'b0); send_sample(SMIN, 1'b1);

		// back-to-back single-word sets while the output is held off
		send_gap_max = 0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 30; i++) send_sample(rand_sample(), 1'b1);

		// random sets, mostly short, a few deep enough for upper levels
		items = 0;
		while (items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 99)) inside
				[0:69]:  len = $urandom_range(1, 12);
				[70:91]: len = $urandom_range(13, 130);
				[92:98]: len = $urandom_range(131, 700);
				default: len = $urandom_range(701, 3200);
			endcase
			if (len > RANDOM_ITEMS - items) len = RANDOM_ITEMS - items;
			send_gap_max = gap_limit();
			recv_gap_max = gap_limit();
			send_set(len);
			items += len;
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
